FILE: hdl/emrr_pkg.sv
// shared types, constants and address map of the ethernet mac rx ring register block
// no dependencies
package emrr_pkg;

   localparam int SLOT_BYTES_DEF = 2048;
   localparam int RING_SLOTS_DEF = 8;
   localparam int TX_BYTES_DEF   = 2048;

   localparam int ADDR_W  = 15;
   localparam int FCNT_W  = 12;

   localparam logic [ADDR_W-1:0] A_MACLO   = 15'h0800;
   localparam logic [ADDR_W-1:0] A_MACHI   = 15'h0808;
   localparam logic [ADDR_W-1:0] A_TPLR    = 15'h0810;
   localparam logic [ADDR_W-1:0] A_MDIO    = 15'h0820;
   localparam logic [ADDR_W-1:0] A_RFCS    = 15'h0828;
   localparam logic [ADDR_W-1:0] A_RSR     = 15'h0830;
   localparam logic [ADDR_W-1:0] A_SLOTLEN = 15'h0840;
   localparam logic [ADDR_W-1:0] A_SLOTEND = 15'h0878;
   localparam logic [ADDR_W-1:0] A_TXBUF   = 15'h1000;
   localparam logic [ADDR_W-1:0] A_RXBUF   = 15'h4000;

   localparam logic [31:0] MDIO_RESET = 32'd8;
   localparam logic [7:0]  RX_FILL    = 8'h44;
   localparam logic [7:0]  TX_FILL    = 8'h55;
   localparam int          MACHI_LOOPBACK = 17;
   localparam int          MACHI_RX_ALL   = 22;
   localparam int          MACHI_IRQ_EN   = 23;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_RX    = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      REG_NONE,
      REG_MACLO,
      REG_MACHI,
      REG_TPLR,
      REG_MDIO,
      REG_RFCS,
      REG_RSR,
      REG_SLOT
   } reg_sel_type;

   typedef enum logic [1:0] {
      SRC_REG,
      SRC_TX,
      SRC_RX
   } src_type;

   typedef struct packed {
      cmd_type      cmd;
      logic [14:0]  address;
      logic [63:0]  write_data;
      logic [3:0]   access_bytes;
      logic [7:0]   rx_byte;
      logic         rx_end;
   } req_type;

   typedef struct packed {
      logic [63:0]  read_data;
      logic         irq_line;
      logic         tx_request;
      logic [11:0]  tx_length;
      logic         rx_accepted;
      logic         rx_dropped;
   } rsp_type;

   typedef struct packed {
      logic               rd_en;
      logic               wr_en;
      logic [ADDR_W-1:0]  offset;
      logic [63:0]        wdata;
      logic [3:0]         wcount;
   } buf_cmd_type;

endpackage

FILE: hdl/emrr_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module emrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hdl/emrr_buf.sv
// byte buffer split into eight byte lanes for unaligned 64-bit access
// depends on emrr_pkg and emrr_ram
module emrr_buf #(
   parameter int SIZE = 2048
) (
   input  logic                 clock,
   input  emrr_pkg::buf_cmd_type cmd,
   output logic [63:0]          rdata
);
   import emrr_pkg::*;

   localparam int ROWS = (SIZE + 7) / 8;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [3:0]    wcount_cl;
   logic [7:0]    lane_we;
   logic [RW-1:0] lane_row [8];
   logic [7:0]    lane_wd  [8];
   logic [7:0]    lane_q   [8];
   logic [2:0]    off_lo_ff;
   logic [7:0]    ok_ff;
   logic [7:0]    ok_in;

   assign wcount_cl = (cmd.wcount > 4'd8) ? 4'd8 : cmd.wcount;

   for (genvar j = 0; j < 8; j++) begin : g_lane
      logic [2:0]  bi;
      logic [15:0] sum;
      assign bi  = 3'(j) - cmd.offset[2:0];
      assign sum = {1'b0, cmd.offset} + 16'(bi);
      assign lane_row[j] = (sum < 16'(SIZE)) ? sum[RW+2:3] : '0;
      assign lane_we[j]  = cmd.wr_en && ({1'b0, bi} < wcount_cl) && (sum < 16'(SIZE));
      assign lane_wd[j]  = cmd.wdata[8*bi +: 8];

      emrr_ram #(.WIDTH(8), .DEPTH(ROWS)) u_ram (
         .clock (clock),
         .we    (lane_we[j]),
         .waddr (lane_row[j]),
         .wdata (lane_wd[j]),
         .re    (cmd.rd_en),
         .raddr (lane_row[j]),
         .rdata (lane_q[j])
      );
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         ok_in[i] = ({1'b0, cmd.offset} + 16'(i)) < 16'(SIZE);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         off_lo_ff <= cmd.offset[2:0];
         ok_ff     <= ok_in;
      end
   end

   // realign lanes to byte order, bytes past the end read as zero
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         rdata[8*i +: 8] = lane_q[3'(off_lo_ff + 3'(i))] & {8{ok_ff[i]}};
      end
   end

endmodule

FILE: hdl/eth_mac_rx_ring_registers_top.sv
// top level of the ethernet mac register block with eight-slot receive ring
// depends on emrr_pkg, emrr_buf and emrr_ram
//
// usage
//  - req channel (req_valid / req_stall / req_data) carries one word per bus read,
//    bus write or received frame byte; rsp channel returns exactly one word per
//    request word, in order, with read data, irq state and rx/tx event flags
//  - csr port is an apb-style slave holding the 48-bit station address at offset 0;
//    a write reloads the mac address registers; write it only while idle
//  - a request is held in the middle stage, where the synchronous buffer read lands,
//    then in the output register
//  - throughput: one word per cycle while req_stall is low; buffer accesses of any
//    alignment hit eight byte-lane rams once each, so each word needs one access
//  - reset: registers go to their reset values, then a clearing pass writes the
//    fill patterns into both buffers, one 8-byte row per cycle over max(SLOT_BYTES,
//    (TX_BYTES+7)/8) rows (2048 with default parameters); req_stall stays high
//    during the pass
//  - when the receiver stalls, the output register holds its word and one more
//    word may sit in the middle stage; after that req_stall rises
//  - all register and ring state is updated at the accept edge, so the
//    response word carries the state after its own request
module eth_mac_rx_ring_registers_top #(
   parameter int SLOT_BYTES = emrr_pkg::SLOT_BYTES_DEF,
   parameter int TX_BYTES   = emrr_pkg::TX_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  emrr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output emrr_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [63:0]       csr_pwdata,
   output logic [63:0]       csr_prdata,
   output logic              csr_pready
);
   import emrr_pkg::*;

   localparam int RING     = RING_SLOTS_DEF;
   localparam int RX_TOTAL = RING * SLOT_BYTES;
   localparam int SB_W     = $clog2(SLOT_BYTES);
   localparam int TX_ROWS  = (TX_BYTES + 7) / 8;
   localparam int CLR_ROWS = (SLOT_BYTES > TX_ROWS) ? SLOT_BYTES : TX_ROWS;
   localparam int CLR_W    = $clog2(CLR_ROWS);

   // architectural registers
   logic [47:0]       init_mac_ff;
   logic [31:0]       maclo_ff, maclo_in;
   logic [31:0]       machi_ff, machi_in;
   logic [31:0]       mdio_ff, mdio_in;
   logic [31:0]       tplr_ff, tplr_in;
   logic [11:0]       rsr_ff, rsr_in;       // last, next, first; avail and irq derived
   logic [31:0]       slen_ff [RING];
   logic [31:0]       slen_in [RING];
   logic [FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic              busy_ff, busy_in;
   logic              full_ff, full_in;
   logic              miss_ff, miss_in;
   logic              grp_ff, grp_in;

   // clearing pass
   logic              clr_ff;
   logic [CLR_W-1:0]  clr_cnt_ff;

   // pipeline
   logic              s1_v_ff;
   rsp_type           s1_rsp_ff, s1_rsp_in;
   src_type           s1_src_ff, s1_src_in;
   logic              out_v_ff;
   rsp_type           out_ff, out_in;

   logic              accept, s1_move, cfg_wr;
   buf_cmd_type       tx_cmd, rx_cmd;
   logic [63:0]       tx_rd, rx_rd;
   logic [63:0]       rd_sel;

   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && (csr_paddr == 4'd0);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[3] == 1'b0) ? {16'd0, init_mac_ff} : 64'd0;

   assign s1_move   = s1_v_ff && !(out_v_ff && rsp_stall);
   assign req_stall = clr_ff || (s1_v_ff && !s1_move);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // request decode and next state
   always_comb begin
      logic [14:0]       a;
      logic              in_tx, in_rx, full, pass, bigend;
      reg_sel_type       rsel;
      logic [3:0]        first, nxt, last;
      logic [2:0]        slot;
      logic [FCNT_W-1:0] p, cnt;
      logic [7:0]        sbyte;
      logic [63:0]       regval;
      logic [31:0]       w;

      a      = req_data.address;
      w      = req_data.write_data[31:0];
      first  = rsr_ff[3:0];
      nxt    = rsr_ff[7:4];
      last   = rsr_ff[11:8];
      slot   = nxt[2:0];
      full   = nxt == (first + last);
      in_tx  = (a >= A_TXBUF) && ({1'b0, a} < (16'(A_TXBUF) + 16'(TX_BYTES)));
      in_rx  = (a >= A_RXBUF) && ({1'b0, a} < (16'(A_RXBUF) + 16'(RX_TOTAL)));

      priority if (a >= A_SLOTLEN && a <= A_SLOTEND)  rsel = REG_SLOT;
      else if (a[14:2] == A_MACLO[14:2])              rsel = REG_MACLO;
      else if (a[14:2] == A_MACHI[14:2])              rsel = REG_MACHI;
      else if (a[14:2] == A_TPLR[14:2])               rsel = REG_TPLR;
      else if (a[14:2] == A_MDIO[14:2])               rsel = REG_MDIO;
      else if (a[14:2] == A_RFCS[14:2])               rsel = REG_RFCS;
      else if (a[14:2] == A_RSR[14:2])                rsel = REG_RSR;
      else                                            rsel = REG_NONE;

      unique case (rsel)
         REG_MACLO: regval = {32'd0, maclo_ff};
         REG_MACHI: regval = {32'd0, machi_ff};
         REG_TPLR:  regval = {32'd0, tplr_ff};
         REG_MDIO:  regval = {32'd0, mdio_ff};
         REG_RFCS:  regval = 64'd0;
         REG_RSR:   regval = {50'd0, (nxt != first) && machi_ff[MACHI_IRQ_EN],
                              nxt != first, rsr_ff};
         REG_SLOT:  regval = {32'd0, slen_ff[a[5:3]]};
         default:   regval = '1;
      endcase

      maclo_in = maclo_ff;
      machi_in = machi_ff;
      mdio_in  = mdio_ff;
      tplr_in  = tplr_ff;
      rsr_in   = rsr_ff;
      slen_in  = slen_ff;
      fcnt_in  = fcnt_ff;
      busy_in  = busy_ff;
      full_in  = full_ff;
      miss_in  = miss_ff;
      grp_in   = grp_ff;
      tx_cmd   = '0;
      rx_cmd   = '0;
      s1_rsp_in = '0;
      s1_src_in = SRC_REG;
      p      = '0;
      cnt    = '0;
      sbyte  = '0;
      pass   = 1'b0;
      bigend = 1'b0;

      if (clr_ff) begin
         tx_cmd.wr_en  = 1'b1;
         tx_cmd.offset = ADDR_W'(clr_cnt_ff) << 3;
         tx_cmd.wdata  = {8{TX_FILL}};
         tx_cmd.wcount = 4'd8;
         rx_cmd.wr_en  = 1'b1;
         rx_cmd.offset = ADDR_W'(clr_cnt_ff) << 3;
         rx_cmd.wdata  = {8{RX_FILL}};
         rx_cmd.wcount = 4'd8;
      end else if (accept) begin
         unique case (req_data.cmd)
            CMD_READ: begin
               tx_cmd.offset = a - A_TXBUF;
               rx_cmd.offset = a - A_RXBUF;
               if (in_tx) begin
                  tx_cmd.rd_en = 1'b1;
                  s1_src_in    = SRC_TX;
               end else if (in_rx) begin
                  rx_cmd.rd_en = 1'b1;
                  s1_src_in    = SRC_RX;
               end else begin
                  s1_rsp_in.read_data = regval;
               end
            end
            CMD_WRITE: begin
               tx_cmd.offset = a - A_TXBUF;
               tx_cmd.wdata  = req_data.write_data;
               tx_cmd.wcount = req_data.access_bytes;
               rx_cmd.offset = a - A_RXBUF;
               rx_cmd.wdata  = req_data.write_data;
               rx_cmd.wcount = req_data.access_bytes;
               if (in_tx) begin
                  tx_cmd.wr_en = 1'b1;
               end else if (in_rx) begin
                  rx_cmd.wr_en = 1'b1;
               end else begin
                  unique case (rsel)
                     REG_MACLO: maclo_in = w;
                     REG_MACHI: machi_in = w;
                     REG_TPLR: begin
                        tplr_in = {1'b0, w[30:0]};
                        s1_rsp_in.tx_request = 1'b1;
                        s1_rsp_in.tx_length  = w[11:0];
                     end
                     REG_MDIO:  mdio_in = w | MDIO_RESET;
                     REG_RFCS:  rsr_in[11:8] = w[3:0];
                     REG_RSR:   rsr_in[3:0] = w[3:0];
                     REG_SLOT:  slen_in[a[5:3]] = w;
                     default:   ;
                  endcase
               end
            end
            CMD_RX: begin
               // a new frame latches ring-full and clears its filter flags
               if (!busy_ff) begin
                  busy_in = 1'b1;
                  full_in = full;
                  miss_in = 1'b0;
                  grp_in  = 1'b0;
                  p       = '0;
               end else begin
                  p = fcnt_ff;
               end
               unique case (p[2:0])
                  3'd0:    sbyte = machi_ff[15:8];
                  3'd1:    sbyte = machi_ff[7:0];
                  3'd2:    sbyte = maclo_ff[31:24];
                  3'd3:    sbyte = maclo_ff[23:16];
                  3'd4:    sbyte = maclo_ff[15:8];
                  default: sbyte = maclo_ff[7:0];
               endcase
               if (p == '0 && req_data.rx_byte[0]) begin
                  grp_in = 1'b1;
               end
               if (p < FCNT_W'(6) && req_data.rx_byte != sbyte) begin
                  miss_in = 1'b1;
               end
               bigend = p >= FCNT_W'(SLOT_BYTES);
               rx_cmd.offset = (ADDR_W'(slot) << SB_W) + ADDR_W'(p);
               rx_cmd.wdata  = {56'd0, req_data.rx_byte};
               rx_cmd.wcount = 4'd1;
               rx_cmd.wr_en  = !full_in && !bigend;
               cnt     = bigend ? p : p + FCNT_W'(1);
               fcnt_in = cnt;
               if (req_data.rx_end) begin
                  pass = grp_in || machi_ff[MACHI_RX_ALL] || machi_ff[MACHI_LOOPBACK]
                         || (!miss_in && cnt >= FCNT_W'(6));
                  if (full_in) begin
                     s1_rsp_in.rx_dropped = 1'b1;
                  end else if (pass) begin
                     slen_in[slot] = 32'(cnt) + 32'd4;
                     rsr_in[7:4]   = nxt + 4'd1;
                     s1_rsp_in.rx_accepted = 1'b1;
                  end
                  busy_in = 1'b0;
                  full_in = 1'b0;
                  miss_in = 1'b0;
                  grp_in  = 1'b0;
                  fcnt_in = '0;
               end
            end
            default: ;
         endcase
         s1_rsp_in.irq_line = (rsr_in[7:4] != rsr_in[3:0]) && machi_in[MACHI_IRQ_EN];
      end
      if (cfg_wr) begin
         maclo_in = csr_pwdata[31:0];
         machi_in = {16'd0, csr_pwdata[47:32]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_mac_ff <= '0;
         maclo_ff    <= '0;
         machi_ff    <= '0;
         mdio_ff     <= MDIO_RESET;
         tplr_ff     <= '0;
         rsr_ff      <= '0;
         for (int i = 0; i < RING; i++) begin
            slen_ff[i] <= '0;
         end
         fcnt_ff     <= '0;
         busy_ff     <= 1'b0;
         full_ff     <= 1'b0;
         miss_ff     <= 1'b0;
         grp_ff      <= 1'b0;
         clr_ff      <= 1'b1;
         clr_cnt_ff  <= '0;
         s1_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
      end else begin
         if (cfg_wr) begin
            init_mac_ff <= csr_pwdata[47:0];
         end
         maclo_ff <= maclo_in;
         machi_ff <= machi_in;
         mdio_ff  <= mdio_in;
         tplr_ff  <= tplr_in;
         rsr_ff   <= rsr_in;
         slen_ff  <= slen_in;
         fcnt_ff  <= fcnt_in;
         busy_ff  <= busy_in;
         full_ff  <= full_in;
         miss_ff  <= miss_in;
         grp_ff   <= grp_in;
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + CLR_W'(1);
            if (clr_cnt_ff == CLR_W'(CLR_ROWS - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (accept) begin
            s1_v_ff <= 1'b1;
         end else if (s1_move) begin
            s1_v_ff <= 1'b0;
         end
         if (s1_move) begin
            out_v_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_v_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_rsp_ff <= s1_rsp_in;
         s1_src_ff <= s1_src_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   // buffer read data lands in the cycle after accept
   always_comb begin
      unique case (s1_src_ff)
         SRC_TX:  rd_sel = tx_rd;
         SRC_RX:  rd_sel = rx_rd;
         default: rd_sel = s1_rsp_ff.read_data;
      endcase
      out_in           = s1_rsp_ff;
      out_in.read_data = rd_sel;
   end

   emrr_buf #(.SIZE(TX_BYTES)) u_tx_buf (
      .clock (clock),
      .cmd   (tx_cmd),
      .rdata (tx_rd)
   );

   emrr_buf #(.SIZE(RX_TOTAL)) u_rx_buf (
      .clock (clock),
      .cmd   (rx_cmd),
      .rdata (rx_rd)
   );

endmodule

FILE: tb/eth_mac_rx_ring_registers_top_test.sv
// self-checking testbench for eth_mac_rx_ring_registers_top
// depends on emrr_pkg and the block's rtl; a scoreboard class predicts every response word
`timescale 1ns / 1ps

module eth_mac_rx_ring_registers_top_test;
   import emrr_pkg::*;

   class emrr_scoreboard;
      localparam int RX_TOTAL = SLOT_BYTES_DEF * RING_SLOTS_DEF;

      logic [31:0] mac_lo, mac_hi, mdio, tplr;
      logic [13:0] rsr;
      logic [31:0] slot_len [RING_SLOTS_DEF];
      logic [7:0]  rx_mem [RX_TOTAL];
      logic [7:0]  tx_mem [TX_BYTES_DEF];
      int          frame_cnt;
      bit          in_frame, met_full, dest_miss, dest_group;
      rsp_type     pending_rsp [$];
      bit          failed;

      function new();
         mac_lo = 0; mac_hi = 0; mdio = MDIO_RESET; tplr = 0; rsr = 0;
         foreach (slot_len[i]) slot_len[i] = 0;
         foreach (rx_mem[i]) rx_mem[i] = RX_FILL;
         foreach (tx_mem[i]) tx_mem[i] = TX_FILL;
         frame_cnt = 0; in_frame = 0; met_full = 0; dest_miss = 0; dest_group = 0;
         failed = 0;
      endfunction

      function void refresh_status();
         bit avail;
         avail = rsr[7:4] != rsr[3:0];
         rsr[12] = avail;
         rsr[13] = avail && mac_hi[MACHI_IRQ_EN];
      endfunction

      function void load_station(logic [47:0] v);
         mac_lo = v[31:0];
         mac_hi = {16'h0, v[47:32]};
         refresh_status();
      endfunction

      function logic [7:0] station(int p);
         if (p < 2) return mac_hi[8*(1-p) +: 8];
         return mac_lo[8*(5-p) +: 8];
      endfunction

      function reg_sel_type decode(logic [14:0] a, output int idx);
         idx = 0;
         if (a >= A_SLOTLEN && a <= A_SLOTEND) begin
            idx = int'((a - A_SLOTLEN) >> 3) & (RING_SLOTS_DEF - 1);
            return REG_SLOT;
         end
         case (a >> 2)
            A_MACLO >> 2: return REG_MACLO;
            A_MACHI >> 2: return REG_MACHI;
            A_TPLR >> 2:  return REG_TPLR;
            A_MDIO >> 2:  return REG_MDIO;
            A_RFCS >> 2:  return REG_RFCS;
            A_RSR >> 2:   return REG_RSR;
            default:      return REG_NONE;
         endcase
      endfunction

      function logic [63:0] bus_read(logic [14:0] a);
         logic [63:0] v;
         int idx, off;
         v = 0;
         if (a >= A_TXBUF && a < A_TXBUF + TX_BYTES_DEF) begin
            off = int'(a - A_TXBUF);
            for (int i = 0; i < 8; i++)
               if (off + i < TX_BYTES_DEF) v[8*i +: 8] = tx_mem[off + i];
            return v;
         end
         if (a >= A_RXBUF) begin
            off = int'(a - A_RXBUF);
            for (int i = 0; i < 8; i++)
               if (off + i < RX_TOTAL) v[8*i +: 8] = rx_mem[off + i];
            return v;
         end
         case (decode(a, idx))
            REG_MACLO: return 64'(mac_lo);
            REG_MACHI: return 64'(mac_hi);
            REG_TPLR:  return 64'(tplr);
            REG_MDIO:  return 64'(mdio);
            REG_RFCS:  return 64'd0;
            REG_RSR:   return 64'(rsr);
            REG_SLOT:  return 64'(slot_len[idx]);
            default:   return '1;
         endcase
      endfunction

      function void bus_write(req_type r, inout rsp_type o);
         int idx, off, n;
         logic [31:0] w;
         w = r.write_data[31:0];
         n = (r.access_bytes > 8) ? 8 : int'(r.access_bytes);
         if (r.address >= A_TXBUF && r.address < A_TXBUF + TX_BYTES_DEF) begin
            off = int'(r.address - A_TXBUF);
            for (int i = 0; i < n; i++)
               if (off + i < TX_BYTES_DEF) tx_mem[off + i] = r.write_data[8*i +: 8];
            return;
         end
         if (r.address >= A_RXBUF) begin
            off = int'(r.address - A_RXBUF);
            for (int i = 0; i < n; i++)
               if (off + i < RX_TOTAL) rx_mem[off + i] = r.write_data[8*i +: 8];
            return;
         end
         case (decode(r.address, idx))
            REG_MACLO: mac_lo = w;
            REG_MACHI: begin mac_hi = w; refresh_status(); end
            REG_TPLR: begin
               tplr = {1'b0, w[30:0]};
               o.tx_request = 1'b1;
               o.tx_length = w[11:0];
            end
            REG_MDIO: mdio = w | MDIO_RESET;
            REG_RFCS: begin rsr[11:8] = w[3:0]; refresh_status(); end
            REG_RSR: begin rsr[3:0] = w[3:0]; refresh_status(); end
            REG_SLOT: slot_len[idx] = w;
            default: ;
         endcase
      endfunction

      function void rx_byte_in(logic [7:0] b, logic last, inout rsp_type o);
         int slot, p;
         slot = int'(rsr[6:4]);
         if (!in_frame) begin
            in_frame = 1;
            met_full = rsr[7:4] == 4'(rsr[3:0] + rsr[11:8]);
            dest_miss = 0; dest_group = 0; frame_cnt = 0;
         end
         p = frame_cnt;
         if (p == 0 && b[0]) dest_group = 1;
         if (p < 6 && b != station(p)) dest_miss = 1;
         if (!met_full && p < SLOT_BYTES_DEF) rx_mem[slot * SLOT_BYTES_DEF + p] = b;
         if (frame_cnt < SLOT_BYTES_DEF) frame_cnt++;
         if (!last) return;
         if (met_full) o.rx_dropped = 1'b1;
         else if (dest_group || mac_hi[MACHI_RX_ALL] || mac_hi[MACHI_LOOPBACK] ||
                  (!dest_miss && frame_cnt >= 6)) begin
            slot_len[slot] = 32'(frame_cnt + 4);
            rsr[7:4] = rsr[7:4] + 4'd1;
            refresh_status();
            o.rx_accepted = 1'b1;
         end
         in_frame = 0;
         frame_cnt = 0;
      endfunction

      // note an accepted request word and queue the response it must produce
      function void note(req_type r);
         rsp_type o;
         o = '0;
         case (r.cmd)
            CMD_READ:  o.read_data = bus_read(r.address);
            CMD_WRITE: bus_write(r, o);
            CMD_RX:    rx_byte_in(r.rx_byte, r.rx_end, o);
            default:   ;
         endcase
         o.irq_line = rsr[13];
         pending_rsp.push_back(o);
      endfunction

      function void check(rsp_type got);
         rsp_type e;
         if (pending_rsp.size() == 0) begin
            $error("response word with nothing expected: %h", got);
            failed = 1;
            return;
         end
         e = pending_rsp.pop_front();
         if (got.read_data !== e.read_data) begin
            $error("read_data expected %h got %h", e.read_data, got.read_data); failed = 1;
         end
         if (got.irq_line !== e.irq_line) begin
            $error("irq_line expected %b got %b", e.irq_line, got.irq_line); failed = 1;
         end
         if (got.tx_request !== e.tx_request) begin
            $error("tx_request expected %b got %b", e.tx_request, got.tx_request); failed = 1;
         end
         if (got.tx_length !== e.tx_length) begin
            $error("tx_length expected %h got %h", e.tx_length, got.tx_length); failed = 1;
         end
         if (got.rx_accepted !== e.rx_accepted) begin
            $error("rx_accepted expected %b got %b", e.rx_accepted, got.rx_accepted);
            failed = 1;
         end
         if (got.rx_dropped !== e.rx_dropped) begin
            $error("rx_dropped expected %b got %b", e.rx_dropped, got.rx_dropped);
            failed = 1;
         end
      endfunction
   endclass

   localparam logic [3:0] CSR_STATION = 4'd0;   // only csr register, 64-bit spacing
   localparam int IDLE_LIMIT = 20000;            // covers the buffer clearing pass
   localparam int ITEM_TARGET = 1700;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_data;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [63:0] csr_pwdata = 0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   emrr_scoreboard ring_sb = new();
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int hold_off = 0;           // long receiver stall, counted down by the receiver
   int idle_cycles = 0;
   int words_sent = 0;

   eth_mac_rx_ring_registers_top uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: random stall, or a long hold-off so the pipe fills and req_stall rises
   always @(posedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // response checker, samples values from before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ring_sb.check(rsp_data);
   end

   // watchdog on cycles with no word moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one word, sometimes after a random gap, and wait for acceptance
   task automatic send(req_type r);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      ring_sb.note(r);
      words_sent++;
   endtask

   // other fields carry random junk so every bit of them moves
   function automatic req_type bus_word(cmd_type c, logic [14:0] a, logic [63:0] d,
                                        logic [3:0] n);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom});
      r.cmd = c; r.address = a; r.write_data = d; r.access_bytes = n;
      return r;
   endfunction

   function automatic req_type rx_word(logic [7:0] b, logic last);
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom});
      r.cmd = CMD_RX; r.rx_byte = b; r.rx_end = last;
      return r;
   endfunction

   function automatic req_type random_bus_word();
      logic [14:0] a;
      logic [63:0] d;
      cmd_type c;
      d = {$urandom, $urandom};
      c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
      case ($urandom_range(11))
         0, 1, 2: a = A_MACLO + 15'($urandom_range(127));
         3:       a = A_TXBUF + 15'($urandom_range(2047));
         4:       a = A_TXBUF + 15'd2040 + 15'($urandom_range(7));   // runs off the end
         5, 6:    a = A_RXBUF + 15'($urandom_range(16383));
         7:       a = 15'($urandom);
         8, 9: begin a = A_RSR; c = CMD_WRITE; end          // free ring slots
         default: begin a = A_RFCS; c = CMD_WRITE; end
      endcase
      return bus_word(c, a, d, 4'($urandom_range(15)));
   endfunction

   // one frame, mostly addressed to the station or a group, with bus words mixed in
   task automatic send_frame(int len);
      int kind;
      logic [7:0] b;
      kind = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(99) < 8) send(random_bus_word());
         b = 8'($urandom);
         if (kind <= 1 && i < 6) b = ring_sb.station(i);
         if (kind == 1 && i == 5 && $urandom_range(3) == 0) b = ~b;   // near miss
         if (kind == 2 && i == 0) b[0] = 1;
         send(rx_word(b, i == len - 1));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (ring_sb.pending_rsp.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [47:0] v);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= CSR_STATION; csr_pwdata <= {16'h0, v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      ring_sb.load_station(v);
   endtask

   task automatic random_phase(int count);
      int stop;
      stop = words_sent + count;
      while (words_sent < stop) begin
         case ($urandom_range(19))
            0:       send(bus_word(CMD_NOP, 15'($urandom), {$urandom, $urandom},
                                   4'($urandom)));
            1:       begin
               req_type r;
               r = rx_word(8'($urandom), 1'($urandom));   // rx fields on a non-rx word
               r.cmd = CMD_READ;
               send(r);
            end
            2, 3, 4, 5, 6, 7, 8: send(random_bus_word());
            default: send_frame($urandom_range(1, 24));
         endcase
      end
   endtask

   initial begin
      reset = 1;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      @(posedge clock);
      while (req_stall) @(posedge clock);          // buffer clearing pass
      csr_write(48'h02_11_22_33_44_55);

      // directed: every register, buffer ends, unmapped space, nop
      send(bus_word(CMD_READ, A_MACLO, 0, 8));
      send(bus_word(CMD_READ, A_MACHI, 0, 8));
      send(bus_word(CMD_READ, A_MDIO, 0, 8));
      send(bus_word(CMD_WRITE, A_MDIO, 64'hFFFF_FFFF_0000_0000, 8));
      send(bus_word(CMD_READ, A_MDIO, 0, 8));
      send(bus_word(CMD_WRITE, A_TPLR, 64'hFFFF_FFFF_FFFF_FFFF, 8));
      send(bus_word(CMD_READ, A_TPLR, 0, 8));
      send(bus_word(CMD_WRITE, A_RFCS + 15'd2, 64'h0, 8));
      send(bus_word(CMD_READ, A_RFCS, 0, 8));
      send(bus_word(CMD_WRITE, A_SLOTEND, 64'hDEAD_BEEF_CAFE_F00D, 8));
      send(bus_word(CMD_READ, A_SLOTEND, 0, 8));
      send(bus_word(CMD_READ, A_SLOTEND + 15'd4, 0, 8));   // past the slot array
      send(bus_word(CMD_READ, 15'h7FFF, 0, 8));           // last rx buffer byte, the rest of the word reads zeros
      send(bus_word(CMD_WRITE, A_TXBUF + 15'd2044, 64'h0123_4567_89AB_CDEF, 8));
      send(bus_word(CMD_READ, A_TXBUF + 15'd2042, 0, 8));
      send(bus_word(CMD_WRITE, A_TXBUF, 64'h1, 0));       // writes nothing
      send(bus_word(CMD_READ, A_TXBUF, 0, 8));
      send(bus_word(CMD_NOP, A_MACLO, 64'h0, 8));
      // ring full at reset: this short frame is dropped
      send(rx_word(8'h02, 0));
      send(rx_word(8'h11, 1));
      send(bus_word(CMD_WRITE, A_RFCS, 64'h4, 8));        // last = 4 opens the ring
      send(bus_word(CMD_WRITE, A_MACHI, 64'h0080_0211, 8)); // irq enable
      for (int i = 0; i < 6; i++) send(rx_word(ring_sb.station(i), i == 5));
      send(bus_word(CMD_READ, A_RSR, 0, 8));

      // sender sparse, receiver mostly stalled
      sender_idle_pct = 27; receiver_idle_pct = 77;
      random_phase(ITEM_TARGET / 3);
      wait_drained();
      csr_write(48'hFFFF_FFFF_FFFF);

      // sender mostly idle, receiver sparse
      sender_idle_pct = 77; receiver_idle_pct = 27;
      random_phase(ITEM_TARGET / 3);
      wait_drained();
      csr_write(0);
      csr_write(48'({$urandom, $urandom}));

      // full speed, starting with a long receiver hold-off to back up the pipe
      sender_idle_pct = 0; receiver_idle_pct = 0;
      send(bus_word(CMD_WRITE, A_RFCS, 64'h8, 8));
      hold_off = 60;
      random_phase(40);
      send(bus_word(CMD_READ, A_RSR, 0, 8));
      random_phase(ITEM_TARGET / 3);
      req_valid <= 0;
      wait_drained();

      if (!ring_sb.failed && ring_sb.pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
